// File: design/bb3_pkg.sv
// shared types and constants for the 3x3 box blur
package bb3_pkg;

   localparam int PIX_W      = 24;
   localparam int CH_W       = 8;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 13;
   localparam int DIM_W      = 14;
   localparam int FW_W       = 11;
   localparam int FH_W       = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int REM_W      = 13;
   localparam int CNT_W      = 4;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // one blur job handed from front to back
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [DIM_W-1:0] width;
      logic [FH_W-1:0]  height;
      logic             last;
   } bb3_job_type;

   // back status seen by the front
   typedef struct packed {
      logic busy;
      logic pop;
   } bb3_back_status_type;

endpackage

// File: design/box_blur_3x3_edge_aware.sv
// top level of the streaming 3x3 edge-aware rgb box blur
//
// input queue side: raise push with req_type and the pixel colors; the
// transaction is taken on a clock edge where push is high and full is low.
// a pixel transaction stores the pixel, a drain transaction releases one
// result still pending after the frame's last pixel.
// result queue side: while empty is low the oldest result sits on the rsp_
// ports; pop on a cycle with empty low takes it. frame_end marks the last
// result of a frame.
// csr side: csr_index 0 writes frame_width, 1 writes frame_height; csr_ready
// is always high. write only while no transaction is in flight.
// stalls: a transaction that yields no result leaves full low; one that
// yields a result keeps full high while it passes the job queue, nine
// window taps read from the single read port of the line store (one per
// cycle), a step to close the sum, an 8 step shift-subtract divide for the
// rounded mean and the load of the output register, once that is free.
// when pop is held low a finished result waits in the output register; the
// next transaction is still taken, its result waits in the back end.
// reset (synchronous, active high) clears positions and empties both sides;
// sizes return to 640 x 480. the line store is not cleared.
module box_blur_3x3_edge_aware
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_type,
   input  logic [CH_W-1:0]       req_in_red,
   input  logic [CH_W-1:0]       req_in_green,
   input  logic [CH_W-1:0]       req_in_blue,
   output logic                  empty,
   input  logic                  pop,
   output logic [CH_W-1:0]       rsp_out_red,
   output logic [CH_W-1:0]       rsp_out_green,
   output logic [CH_W-1:0]       rsp_out_blue,
   output logic                  rsp_frame_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = $clog2(4*MAX_WIDTH);

   logic [FW_W-1:0]     frame_width_ff, frame_width_in;
   logic [FH_W-1:0]     frame_height_ff, frame_height_in;
   bb3_back_status_type back_status;
   bb3_job_type         job;
   logic                job_valid;
   logic                mem_wr_en, mem_rd_en;
   logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
   logic [PIX_W-1:0]    mem_wr_data, mem_rd_data;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_data[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_data[FH_W-1:0];
            default: begin
               frame_width_in  = frame_width_ff;
               frame_height_in = frame_height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // front end
   bb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_type     (req_type),
      .req_pixel    ({req_in_red, req_in_green, req_in_blue}),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .back_status  (back_status),
      .job_valid    (job_valid),
      .job          (job),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data)
   );

   // four-row line store
   bb3_ram #(.WIDTH(PIX_W), .DEPTH(4*MAX_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // back end
   bb3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .status        (back_status),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end)
   );

   // the line store is never written while the back end reads it
   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !back_status.busy)
      else $error("line store written during window read");

   // the back end takes a job only when one is queued
   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      back_status.pop |-> job_valid)
      else $error("job taken from empty queue");

   // a job taken keeps the input side stalled on the next cycle
   a_stall_after_pop: assert property (@(posedge clock) disable iff (reset)
      back_status.pop |=> full)
      else $error("input accepted while a job is in progress");

endmodule

// File: design/bb3_ram.sv
// generic single write, single read ram with registered read
module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bb3_front.sv
// front end: accepts transactions, tracks frame position, queues blur jobs
module bb3_front
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic                             req_type,
   input  logic [PIX_W-1:0]                 req_pixel,
   input  logic [FW_W-1:0]                  frame_width,
   input  logic [FH_W-1:0]                  frame_height,
   input  bb3_back_status_type              back_status,
   output logic                             job_valid,
   output bb3_job_type                      job,
   output logic                             mem_wr_en,
   output logic [$clog2(4*MAX_WIDTH)-1:0]   mem_wr_addr,
   output logic [PIX_W-1:0]                 mem_wr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int AW = $clog2(4*MAX_WIDTH);

   logic [CW-1:0]    ic_ff, ic_in, oc_ff, oc_in;
   logic [ROW_W-1:0] ir_ff, ir_in, or_ff, or_in;

   logic             accept;
   logic [DIM_W-1:0] fw_ext, eff_w;
   logic [FH_W-1:0]  eff_h;
   logic [CW-1:0]    ic_a, oc_a;
   logic [ROW_W-1:0] ir_a, or_a;
   logic             write_px;
   logic [CW-1:0]    ic_b;
   logic [ROW_W-1:0] ir_b;
   logic [ROW_W:0]   or1, lr;
   logic [DIM_W-1:0] oc1, lc;
   logic             ready, last;
   bb3_job_type      new_job;

   bb3_job_type      q_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             q_push, q_pop;

   assign accept = push && !full;

   // effective frame size
   always_comb begin
      fw_ext = DIM_W'(frame_width);
      if (frame_width == '0) begin
         eff_w = DIM_W'(1);
      end else if (fw_ext > DIM_W'(MAX_WIDTH)) begin
         eff_w = DIM_W'(MAX_WIDTH);
      end else begin
         eff_w = fw_ext;
      end
      eff_h = (frame_height == '0) ? FH_W'(1) : frame_height;
   end

   // position tracking and readiness
   always_comb begin
      // wrap counters beyond the current width
      ic_a = ic_ff;
      ir_a = ir_ff;
      if (DIM_W'(ic_ff) >= eff_w) begin
         ic_a = '0;
         ir_a = ir_ff + ROW_W'(1);
      end
      oc_a = oc_ff;
      or_a = or_ff;
      if (DIM_W'(oc_ff) >= eff_w) begin
         oc_a = '0;
         or_a = or_ff + ROW_W'(1);
      end
      // store the pixel
      write_px = (req_type == REQ_PIXEL) && (ir_a < eff_h);
      ic_b = ic_a;
      ir_b = ir_a;
      if (write_px) begin
         if (DIM_W'(ic_a) + DIM_W'(1) >= eff_w) begin
            ic_b = '0;
            ir_b = ir_a + ROW_W'(1);
         end else begin
            ic_b = ic_a + CW'(1);
         end
      end
      // last neighbour of the next result
      or1 = {1'b0, or_a} + (ROW_W+1)'(1);
      lr  = (or1 < {1'b0, eff_h}) ? or1 : ({1'b0, eff_h} - (ROW_W+1)'(1));
      oc1 = DIM_W'(oc_a) + DIM_W'(1);
      lc  = (oc1 < eff_w) ? oc1 : (eff_w - DIM_W'(1));
      ready = (ir_b >= eff_h) || ({1'b0, ir_b} > lr)
              || (({1'b0, ir_b} == lr) && (DIM_W'(ic_b) > lc));
      last = (or1 >= {1'b0, eff_h}) && (oc1 >= eff_w);

      new_job.row    = or_a;
      new_job.col    = COL_W'(oc_a);
      new_job.width  = eff_w;
      new_job.height = eff_h;
      new_job.last   = last;

      // counter next values
      ic_in = ic_ff;
      ir_in = ir_ff;
      oc_in = oc_ff;
      or_in = or_ff;
      if (accept) begin
         ic_in = ic_b;
         ir_in = ir_b;
         oc_in = oc_a;
         or_in = or_a;
         if (ready) begin
            if (last) begin
               ic_in = '0;
               ir_in = '0;
               oc_in = '0;
               or_in = '0;
            end else if (oc1 >= eff_w) begin
               oc_in = '0;
               or_in = or_a + ROW_W'(1);
            end else begin
               oc_in = oc_a + CW'(1);
            end
         end
      end
   end

   // line store write
   assign mem_wr_en   = accept && write_px;
   assign mem_wr_addr = AW'(ir_a[1:0]) * AW'(MAX_WIDTH) + AW'(ic_a);
   assign mem_wr_data = req_pixel;

   // job queue toward the back end
   assign q_push    = accept && ready;
   assign q_pop     = back_status.pop;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rp_ff];
   assign full      = job_valid || back_status.busy;

   always_comb begin
      wp_in  = q_push ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, q_push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[wp_ff] <= new_job;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ic_ff  <= '0;
         ir_ff  <= '0;
         oc_ff  <= '0;
         or_ff  <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         ic_ff  <= ic_in;
         ir_ff  <= ir_in;
         oc_ff  <= oc_in;
         or_ff  <= or_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: design/bb3_back.sv
// back end: gathers the 3x3 window, divides, holds the result
module bb3_back
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   input  bb3_job_type                    job,
   output bb3_back_status_type            status,
   output logic                           mem_rd_en,
   output logic [$clog2(4*MAX_WIDTH)-1:0] mem_rd_addr,
   input  logic [PIX_W-1:0]               mem_rd_data,
   output logic                           empty,
   input  logic                           pop,
   output logic [CH_W-1:0]                rsp_out_red,
   output logic [CH_W-1:0]                rsp_out_green,
   output logic [CH_W-1:0]                rsp_out_blue,
   output logic                           rsp_frame_end
);

   localparam int AW = $clog2(4*MAX_WIDTH);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_SUM  = 5'b00100,
      S_DIV  = 5'b01000,
      S_HOLD = 5'b10000
   } bb3_state_type;

   bb3_state_type    state_ff, state_in;
   bb3_job_type      job_ff, job_in;
   logic [1:0]       dr_ff, dr_in, dc_ff, dc_in;
   logic [2:0]       bit_ff, bit_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [REM_W-1:0] rem_r_ff, rem_r_in, rem_g_ff, rem_g_in, rem_b_ff, rem_b_in;
   logic [CH_W-1:0]  q_r_ff, q_r_in, q_g_ff, q_g_in, q_b_ff, q_b_in;
   logic             pend_vld_ff, pend_vld_in, pend_ok_ff, pend_ok_in;
   logic             pend_rng_ff, pend_rng_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [CH_W-1:0]  out_r_ff, out_r_in, out_g_ff, out_g_in, out_b_ff, out_b_in;
   logic             out_end_ff, out_end_in;

   logic             start;
   logic [COL_W:0]   rr;
   logic [DIM_W-1:0] cc;
   logic             skip, centre, tap_ok;
   logic [REM_W-1:0] div_sh;
   logic             ge_r, ge_g, ge_b;
   logic             out_free;

   assign start         = (state_ff == S_IDLE) && job_valid;
   assign status.pop    = start;
   assign status.busy   = (state_ff != S_IDLE);
   assign out_free      = !rsp_vld_ff || pop;
   assign empty         = !rsp_vld_ff;
   assign rsp_out_red   = out_r_ff;
   assign rsp_out_green = out_g_ff;
   assign rsp_out_blue  = out_b_ff;
   assign rsp_frame_end = out_end_ff;

   // tap address and in-frame check
   always_comb begin
      rr     = (COL_W+1)'(job_ff.row) + (COL_W+1)'(dr_ff) - (COL_W+1)'(1);
      cc     = DIM_W'(job_ff.col) + DIM_W'(dc_ff) - DIM_W'(1);
      centre = (dr_ff == 2'd1) && (dc_ff == 2'd1);
      skip   = ((dr_ff == 2'd0) && (job_ff.row == '0))
               || ((dc_ff == 2'd0) && (job_ff.col == '0));
      tap_ok = !skip && (centre || ((rr < (COL_W+1)'(job_ff.height))
                                    && (cc < job_ff.width)));
      mem_rd_en   = (state_ff == S_READ);
      mem_rd_addr = AW'(rr[1:0]) * AW'(MAX_WIDTH) + AW'(cc[COL_W-1:0]);
   end

   // divisor step
   always_comb begin
      div_sh = REM_W'({n_ff, 1'b0}) << bit_ff;
      ge_r   = rem_r_ff >= div_sh;
      ge_g   = rem_g_ff >= div_sh;
      ge_b   = rem_b_ff >= div_sh;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      dr_in       = dr_ff;
      dc_in       = dc_ff;
      bit_in      = bit_ff;
      n_in        = n_ff;
      rem_r_in    = rem_r_ff;
      rem_g_in    = rem_g_ff;
      rem_b_in    = rem_b_ff;
      q_r_in      = q_r_ff;
      q_g_in      = q_g_ff;
      q_b_in      = q_b_ff;
      pend_vld_in = 1'b0;
      pend_ok_in  = tap_ok;
      pend_rng_in = (cc < DIM_W'(MAX_WIDTH));
      rsp_vld_in  = rsp_vld_ff && !pop;
      out_r_in    = out_r_ff;
      out_g_in    = out_g_ff;
      out_b_in    = out_b_ff;
      out_end_in  = out_end_ff;

      // accumulate 2*pixel+1 per counted tap, giving 2*sum+count
      if (pend_vld_ff && pend_ok_ff) begin
         n_in = n_ff + CNT_W'(1);
         if (pend_rng_ff) begin
            rem_r_in = rem_r_ff + REM_W'({mem_rd_data[23:16], 1'b1});
            rem_g_in = rem_g_ff + REM_W'({mem_rd_data[15:8], 1'b1});
            rem_b_in = rem_b_ff + REM_W'({mem_rd_data[7:0], 1'b1});
         end else begin
            rem_r_in = rem_r_ff + REM_W'(1);
            rem_g_in = rem_g_ff + REM_W'(1);
            rem_b_in = rem_b_ff + REM_W'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_in   = job;
               dr_in    = 2'd0;
               dc_in    = 2'd0;
               n_in     = '0;
               rem_r_in = '0;
               rem_g_in = '0;
               rem_b_in = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            pend_vld_in = 1'b1;
            if (dc_ff == 2'd2) begin
               dc_in = 2'd0;
               if (dr_ff == 2'd2) begin
                  state_in = S_SUM;
               end else begin
                  dr_in = dr_ff + 2'd1;
               end
            end else begin
               dc_in = dc_ff + 2'd1;
            end
         end
         S_SUM: begin
            bit_in   = 3'd7;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (ge_r) rem_r_in = rem_r_ff - div_sh;
            if (ge_g) rem_g_in = rem_g_ff - div_sh;
            if (ge_b) rem_b_in = rem_b_ff - div_sh;
            q_r_in = {q_r_ff[CH_W-2:0], ge_r};
            q_g_in = {q_g_ff[CH_W-2:0], ge_g};
            q_b_in = {q_b_ff[CH_W-2:0], ge_b};
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               out_r_in   = q_r_ff;
               out_g_in   = q_g_ff;
               out_b_in   = q_b_ff;
               out_end_in = job_ff.last;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      dr_ff       <= dr_in;
      dc_ff       <= dc_in;
      bit_ff      <= bit_in;
      n_ff        <= n_in;
      rem_r_ff    <= rem_r_in;
      rem_g_ff    <= rem_g_in;
      rem_b_ff    <= rem_b_in;
      q_r_ff      <= q_r_in;
      q_g_ff      <= q_g_in;
      q_b_ff      <= q_b_in;
      pend_ok_ff  <= pend_ok_in;
      pend_rng_ff <= pend_rng_in;
      out_r_ff    <= out_r_in;
      out_g_ff    <= out_g_in;
      out_b_ff    <= out_b_in;
      out_end_ff  <= out_end_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

endmodule

// File: tb/box_blur_checker.sv
// checker for the 3x3 box blur: predicts blurred pixels and compares them
module box_blur_checker
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  logic                  req_type,
   input  logic [CH_W-1:0]       req_in_red,
   input  logic [CH_W-1:0]       req_in_green,
   input  logic [CH_W-1:0]       req_in_blue,
   input  logic                  empty,
   input  logic                  pop,
   input  logic [CH_W-1:0]       rsp_out_red,
   input  logic [CH_W-1:0]       rsp_out_green,
   input  logic [CH_W-1:0]       rsp_out_blue,
   input  logic                  rsp_frame_end,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    error_count,
   output int                    pending_count,
   output int                    frames_predicted
);

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            frame_end;
   } blurred_pixel_type;

   blurred_pixel_type expected_pixels[$];
   logic [PIX_W-1:0]  line_rows[4][MAX_WIDTH];
   int unsigned       width_reg, height_reg;
   int unsigned       in_col, in_row, out_col, out_row;
   int                errors, frames;

   initial begin
      foreach (line_rows[i, j]) line_rows[i][j] = '0;
      errors = 0;
      frames = 0;
      error_count = 0;
      pending_count = 0;
      frames_predicted = 0;
   end

   // advance the blur state by one transaction; returns 1 when a pixel comes out
   function automatic bit blur_step(input bit is_pixel, input logic [PIX_W-1:0] px,
                                    output blurred_pixel_type res);
      int unsigned w, h, lr, lc, r, c, n, q;
      int          rr, cc;
      int unsigned sums[3];
      logic [PIX_W-1:0] v;
      bit          ready;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg == 0) ? 1 : height_reg;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      // store the incoming pixel
      if (is_pixel && in_row < h) begin
         if (in_col < MAX_WIDTH) line_rows[in_row % 4][in_col] = px;
         if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
         end else begin
            in_col++;
         end
      end
      // is the last neighbor of the next output in
      if (in_row >= h) begin
         ready = 1;
      end else begin
         lr = (out_row + 1 < h) ? out_row + 1 : h - 1;
         lc = (out_col + 1 < w) ? out_col + 1 : w - 1;
         ready = (in_row > lr) || (in_row == lr && in_col > lc);
      end
      if (!ready) return 0;
      // sum the in-frame neighbors, center always counts
      r = out_row;
      c = out_col;
      sums = '{0, 0, 0};
      n = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            if (dr < 0 && r == 0) continue;
            if (dc < 0 && c == 0) continue;
            rr = int'(r) + dr;
            cc = int'(c) + dc;
            if (!(dr == 0 && dc == 0) && (rr >= int'(h) || cc >= int'(w))) continue;
            v = (cc < MAX_WIDTH) ? line_rows[rr % 4][cc] : '0;
            sums[0] += v[23:16];
            sums[1] += v[15:8];
            sums[2] += v[7:0];
            n++;
         end
      end
      for (int k = 0; k < 3; k++) begin
         q = (2 * sums[k] + n) / (2 * n);
         sums[k] = (q > 255) ? 255 : q;
      end
      res.red = sums[0][7:0];
      res.green = sums[1][7:0];
      res.blue = sums[2][7:0];
      res.frame_end = (r + 1 >= h) && (c + 1 >= w);
      if (res.frame_end) begin
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
      end else if (c + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
      return 1;
   endfunction

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // watch every channel on each clock edge
   always @(posedge clock) begin
      blurred_pixel_type res, exp_px;
      if (reset) begin
         width_reg = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         expected_pixels.delete();
      end else begin
         // result transaction
         if (pop && !empty) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %0d/%0d/%0d/%0d",
                        $time, rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end);
               errors++;
            end else begin
               exp_px = expected_pixels.pop_front();
               check_field("red", exp_px.red, rsp_out_red);
               check_field("green", exp_px.green, rsp_out_green);
               check_field("blue", exp_px.blue, rsp_out_blue);
               check_field("frame_end", exp_px.frame_end, rsp_frame_end);
            end
         end
         // register write
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_FRAME_WIDTH) width_reg = csr_data & 12'h7FF;
            else if (csr_index == REG_FRAME_HEIGHT) height_reg = csr_data;
         end
         // input transaction
         if (push && !full) begin
            if (blur_step(req_type == REQ_PIXEL, {req_in_red, req_in_green, req_in_blue},
                          res)) begin
               expected_pixels.push_back(res);
               if (res.frame_end) frames++;
            end
         end
      end
      error_count <= errors;
      pending_count <= expected_pixels.size();
      frames_predicted <= frames;
   end

endmodule

// File: tb/tb_box_blur_3x3_edge_aware.sv
// testbench top for the 3x3 box blur: stimulus, receiver stalls and verdict
module tb_box_blur_3x3_edge_aware;
   import bb3_pkg::*;

   localparam int MAX_WIDTH = 1024;
   localparam int CYCLE_LIMIT = 3000000;

   logic                  clock, reset;
   logic                  push, full, req_type;
   logic [CH_W-1:0]       req_in_red, req_in_green, req_in_blue;
   logic                  empty, pop;
   logic [CH_W-1:0]       rsp_out_red, rsp_out_green, rsp_out_blue;
   logic                  rsp_frame_end;
   logic                  csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    error_count, pending_count, frames_predicted;
   int                    cycles, accepted, burst_left;
   bit                    long_hold;

   box_blur_3x3_edge_aware #(.MAX_WIDTH(MAX_WIDTH)) dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_type(req_type),
      .req_in_red(req_in_red), .req_in_green(req_in_green), .req_in_blue(req_in_blue),
      .empty(empty), .pop(pop), .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_frame_end(rsp_frame_end),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   box_blur_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_type(req_type),
      .req_in_red(req_in_red), .req_in_green(req_in_green), .req_in_blue(req_in_blue),
      .empty(empty), .pop(pop), .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_frame_end(rsp_frame_end),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .error_count(error_count), .pending_count(pending_count),
      .frames_predicted(frames_predicted)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: pop pattern changes every so often, one long hold on request
   initial begin
      int mode;
      pop <= 0;
      mode = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            pop <= 0;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: pop <= 1;
            1: pop <= $urandom_range(0, 1);
            default: pop <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // one input transaction, in bursts with random gaps
   task automatic send_item(input logic kind, input logic [23:0] rgb);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      push <= 1;
      req_type <= kind;
      {req_in_red, req_in_green, req_in_blue} <= rgb;
      do @(posedge clock); while (full);
      accepted++;
   endtask

   // write both frame size registers once every result is out
   task automatic write_sizes(input int w, input int h, input bit touch_unused);
      wait (pending_count == 0);
      repeat (30) @(posedge clock);
      csr_valid <= 1;
      csr_index <= REG_FRAME_WIDTH;
      csr_data <= CSR_DATA_W'(w);
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_FRAME_HEIGHT;
      csr_data <= CSR_DATA_W'(h);
      do @(posedge clock); while (!csr_ready);
      if (touch_unused) begin
         // index with no register behind it
         csr_index <= '1;
         csr_data <= CSR_DATA_W'($urandom_range(0, 4095));
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 0;
   endtask

   // one whole frame: pixels, then drain transactions until the frame end
   task automatic run_frame(input int w, input int h, input bit extremes);
      int ew, eh, start;
      logic [23:0] rgb;
      write_sizes(w, h, 0);
      ew = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      eh = (h == 0) ? 1 : h;
      start = frames_predicted;
      // a drain with nothing pending
      if ($urandom_range(0, 3) == 0) send_item(REQ_DRAIN, 24'($urandom));
      for (int i = 0; i < ew * eh; i++) begin
         for (int k = 0; k < 3; k++)
            rgb[k*8 +: 8] = extremes ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                     : 8'($urandom_range(0, 255));
         send_item(REQ_PIXEL, rgb);
      end
      // a pixel after the frame is in acts as a drain
      if (ew >= 2 && eh >= 2 && $urandom_range(0, 1)) send_item(REQ_PIXEL, 24'($urandom));
      while (frames_predicted == start) send_item(REQ_DRAIN, 24'($urandom));
      push <= 0;
   endtask

   initial begin
      int frame_no;
      reset <= 1;
      push <= 0;
      req_type <= REQ_PIXEL;
      req_in_red <= 0;
      req_in_green <= 0;
      req_in_blue <= 0;
      csr_valid <= 0;
      csr_index <= REG_FRAME_WIDTH;
      csr_data <= 0;
      long_hold = 0;
      accepted = 0;
      burst_left = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: corners only, full window, single pixel, zero sizes
      write_sizes(2, 2, 1);
      run_frame(2, 2, 1);
      run_frame(3, 3, 1);
      run_frame(1, 1, 0);
      run_frame(0, 0, 0);
      run_frame(4, 2, 1);
      // size extremes: width above the maximum, tall single column
      run_frame(2047, 1, 0);
      run_frame(1, 64, 0);
      run_frame(3, 0, 0);
      run_frame(1, 3, 1);

      // random frames, mostly small, up to about 1600 transactions in all
      frame_no = 0;
      while (accepted < 1600) begin
         if (frame_no == 2) long_hold = 1;
         run_frame($urandom_range(1, 10), $urandom_range(1, 8), $urandom_range(0, 7) == 0);
         frame_no++;
      end

      wait (pending_count == 0);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: files.f
design/bb3_pkg.sv
design/bb3_ram.sv
design/bb3_front.sv
design/bb3_back.sv
design/box_blur_3x3_edge_aware.sv
tb/box_blur_checker.sv
tb/tb_box_blur_3x3_edge_aware.sv
